### hw/rtl/sha1_message_digest_unit_defines.svh
`ifndef SHA1_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define SHA1MDU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SHA1MDU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/sha1mdu_pkg.sv
package sha1mdu_pkg;

   typedef logic [31:0]      word_type;
   typedef logic [4:0][31:0] chain_type;
   typedef logic [511:0]     block_type;

   typedef struct packed {
      logic       shift;
      logic [7:0] data;
      logic       start;
      logic       init;
   } core_ctl_type;

   localparam int ROUNDS = 80;
   localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
   localparam logic [6:0] ROUND_F1   = 7'd20;
   localparam logic [6:0] ROUND_F2   = 7'd40;
   localparam logic [6:0] ROUND_F3   = 7'd60;

   localparam word_type K0 = 32'h5A827999;
   localparam word_type K1 = 32'h6ED9EBA1;
   localparam word_type K2 = 32'h8F1BBCDC;
   localparam word_type K3 = 32'hCA62C1D6;

   // H4 leftmost so that element 0 holds H0
   localparam chain_type SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                    32'hEFCDAB89, 32'h67452301};

   localparam logic [5:0] BLOCK_LAST = 6'd63;
   localparam logic [5:0] LEN_START  = 6'd56;
   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [2:0] WORD_LAST  = 3'd4;

endpackage

### hw/rtl/sha1mdu_core.sv
module sha1mdu_core (
   input  logic                     clock,
   input  logic                     reset,
   input  sha1mdu_pkg::core_ctl_type ctl,
   output logic                     done,
   output sha1mdu_pkg::chain_type   chain
);
   import sha1mdu_pkg::*;

   chain_type chain_ff, chain_in;
   chain_type work_ff, work_in;
   block_type win_ff, win_in;
   logic [6:0] round_ff, round_in;
   logic       run_ff, run_in;
   logic       add_ff, add_in;

   word_type a, b, c, d, e;
   word_type f, k, temp, sched, w0;

   always_comb begin
      a     = work_ff[0];
      b     = work_ff[1];
      c     = work_ff[2];
      d     = work_ff[3];
      e     = work_ff[4];
      w0    = win_ff[511 -: 32];
      sched = win_ff[95 -: 32] ^ win_ff[255 -: 32] ^ win_ff[447 -: 32] ^ w0;
      if (round_ff < ROUND_F1) begin
         f = (b & c) | (~b & d);
         k = K0;
      end else if (round_ff < ROUND_F2) begin
         f = b ^ c ^ d;
         k = K1;
      end else if (round_ff < ROUND_F3) begin
         f = (b & c) | (b & d) | (c & d);
         k = K2;
      end else begin
         f = b ^ c ^ d;
         k = K3;
      end
      temp = {a[26:0], a[31:27]} + f + e + k + w0;
   end

   always_comb begin
      chain_in = chain_ff;
      work_in  = work_ff;
      win_in   = win_ff;
      round_in = round_ff;
      run_in   = run_ff;
      add_in   = 1'b0;
      if (ctl.shift) begin
         win_in = {win_ff[503:0], ctl.data};
      end
      if (ctl.init) begin
         chain_in = SHA1_IV;
      end
      if (ctl.start) begin
         work_in  = chain_ff;
         round_in = '0;
         run_in   = 1'b1;
      end
      if (run_ff) begin
         work_in  = {d, c, {b[1:0], b[31:2]}, a, temp};
         win_in   = {win_ff[479:0], sched[30:0], sched[31]};
         round_in = round_ff + 7'd1;
         if (round_ff == ROUND_LAST) begin
            run_in = 1'b0;
            add_in = 1'b1;
         end
      end
      if (add_ff) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= SHA1_IV;
         run_ff   <= 1'b0;
         add_ff   <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         run_ff   <= run_in;
         add_ff   <= add_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      win_ff   <= win_in;
      round_ff <= round_in;
   end

   assign done  = add_ff;
   assign chain = chain_ff;

endmodule

### hw/rtl/sha1_message_digest_unit.sv
// SHA-1 digest of a byte stream, one message byte per req item (req_byte_valid = 0 carries no
// byte; req_last ends the message and may carry a final byte or none). Every 64th byte starts
// a compression (80 rounds on one shared round unit plus the chaining add) during which
// req_ready is low and no new byte is taken.
// After the last item the unit shifts in the 0x80 mark, zero padding and the 64-bit bit
// length one byte per cycle (for each of one or two final blocks, each block followed by its
// compression) and delivers the five digest words H0..H4 as five rsp items, word position 0
// first, last_word on word 4. It then returns to the initial state, ready for the next message.
module sha1_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_pos,
   output logic        rsp_last_word
);
   import sha1mdu_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_COMP = 5'b00010,
      ST_PAD  = 5'b00100,
      ST_LEN  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [60:0] count_ff, count_in;
   logic        fin_ff, fin_in;
   logic        mark_ff, mark_in;
   logic        tail_ff, tail_in;
   logic [2:0]  idx_ff, idx_in;

   core_ctl_type ctl;
   logic         core_done;
   chain_type    chain;
   logic [63:0]  bit_len;
   logic [2:0]   len_sel;

   sha1mdu_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .done  (core_done),
      .chain (chain)
   );

   assign bit_len = {count_ff, 3'b000};
   assign len_sel = 3'd7 - pos_ff[2:0];

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      fin_in   = fin_ff;
      mark_in  = mark_ff;
      tail_in  = tail_ff;
      idx_in   = idx_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_valid) begin
                  ctl.shift = 1'b1;
                  ctl.data  = req_data_byte;
                  pos_in    = pos_ff + 6'd1;
                  count_in  = count_ff + 61'd1;
               end
               if (req_byte_valid && pos_ff == BLOCK_LAST) begin
                  ctl.start = 1'b1;
                  fin_in    = req_last;
                  state_in  = ST_COMP;
               end else if (req_last) begin
                  fin_in   = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_COMP: begin
            if (core_done) begin
               if (!fin_ff) begin
                  state_in = ST_IDLE;
               end else if (tail_ff) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctl.shift = 1'b1;
            ctl.data  = mark_ff ? 8'h00 : PAD_MARK;
            mark_in   = 1'b1;
            pos_in    = pos_ff + 6'd1;
            if (pos_ff == BLOCK_LAST) begin
               ctl.start = 1'b1;
               state_in  = ST_COMP;
            end else if (pos_ff == LEN_START - 6'd1) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            ctl.shift = 1'b1;
            ctl.data  = bit_len[{len_sel, 3'b000} +: 8];
            pos_in    = pos_ff + 6'd1;
            if (pos_ff == BLOCK_LAST) begin
               ctl.start = 1'b1;
               tail_in   = 1'b1;
               state_in  = ST_COMP;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == WORD_LAST) begin
                  ctl.init = 1'b1;
                  idx_in   = '0;
                  pos_in   = '0;
                  count_in = '0;
                  fin_in   = 1'b0;
                  mark_in  = 1'b0;
                  tail_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
         fin_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         fin_ff   <= fin_in;
         mark_ff  <= mark_in;
         tail_ff  <= tail_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain[idx_ff];
   assign rsp_word_pos    = idx_ff;
   assign rsp_last_word   = (idx_ff == WORD_LAST);

endmodule

### hw/rtl/sha1mdu_checker.sv
`include "sha1_message_digest_unit_defines.svh"

module sha1mdu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_pos,
   input logic        rsp_last_word
);

   `SHA1MDU_ASSERT_NOW(a_no_accept_while_out, rsp_valid, !req_ready, "req ready during digest output")

   `SHA1MDU_ASSERT_NOW(a_index_last, rsp_valid, (rsp_word_pos <= 3'd4) && (rsp_last_word == (rsp_word_pos == 3'd4)), "bad word position or last flag")

   `SHA1MDU_ASSERT_NEXT(a_index_step, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && (rsp_word_pos == $past(rsp_word_pos) + 3'd1), "digest words out of order")

   `SHA1MDU_ASSERT_NEXT(a_back_to_idle, rsp_valid && rsp_ready && rsp_last_word, req_ready && !rsp_valid, "not ready after final digest word")

   `SHA1MDU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_pos), "stalled item changed")

endmodule

bind sha1_message_digest_unit sha1mdu_checker u_checker (.*);
